// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check under reset gating.
`define SPM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds across reset.
`define SPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/spm_pkg.sv =====
package spm_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
  localparam int CHAR_W      = 8;
  localparam int PAT_W       = 64;
  localparam int LEN_W       = 4;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CHAR_W-1:0] MASK_CHAR = 8'h2A;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b1;

  typedef struct packed {
    logic load;
    logic pop;
    logic care;
    logic mask;
  } cell_ctrl_t;

endpackage

// ===== rtl/spm_cell.sv =====
module spm_cell (
  input  logic                            clk,
  input  spm_pkg::cell_ctrl_t             ctrl,
  input  logic [spm_pkg::CHAR_W-1:0]      char_in,
  input  logic [spm_pkg::CHAR_W-1:0]      pattern_char,
  input  logic [spm_pkg::CHAR_W-1:0]      neighbour_char,
  output logic [spm_pkg::CHAR_W-1:0]      shift_char,
  output logic                            eq
);

  logic [spm_pkg::CHAR_W-1:0] stored;
  logic [spm_pkg::CHAR_W-1:0] stored_next;
  logic [spm_pkg::CHAR_W-1:0] cur;

  assign cur         = ctrl.load ? char_in : stored;
  assign eq          = !ctrl.care || (cur == pattern_char);
  assign shift_char  = ctrl.mask ? spm_pkg::MASK_CHAR : cur;
  assign stored_next = ctrl.pop ? neighbour_char : cur;

  always_ff @(posedge clk) begin
    stored <= stored_next;
  end

endmodule

// ===== rtl/stream_pattern_masker_unit.sv =====
// Pattern masker: replaces every occurrence of a pattern of up to eight
// bytes in a byte stream by asterisks, keeping byte order.
// Channels: input items (char_in, end_of_text) on in_valid/in_ready,
// result items (char_out, last_out) on out_valid/out_ready, and register
// writes (cfg_index, cfg_data) on cfg_valid/cfg_ready, always ready.
// Register 0 holds the pattern, first byte lowest; register 1 its length,
// capped at eight, zero for pass-through.
// A result enters the output register once the item that completes its
// window is accepted and the output slot is free; the first length-1
// items of a string give no result yet. Throughput is one item and one
// result per cycle while the receiver takes every result, set by the
// single output register and one pop of the cell row per cycle.
// An item marked end_of_text flushes the held bytes one per cycle unless
// stalled, with in_ready low; the final result carries last_out.
// A shorter length written mid-string drains extra bytes the same way on the next item.
// While the receiver stalls, one more item is still taken into the row;
// in_ready then drops until the pending results have gone.
// Reset clears the registers, the held count and the output valid.
module stream_pattern_masker_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spm_pkg::PAT_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [spm_pkg::CHAR_W-1:0]        char_in,
  input  logic                              end_of_text,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [spm_pkg::CHAR_W-1:0]        char_out,
  output logic                              last_out
);

  logic [spm_pkg::PAT_W-1:0] pattern_bytes;
  logic [spm_pkg::LEN_W-1:0] pattern_length;
  logic [spm_pkg::CNT_W-1:0] held;
  logic [spm_pkg::CNT_W-1:0] held_next;
  logic                      busy;
  logic                      busy_next;
  logic                      flush;
  logic                      flush_next;

  logic [spm_pkg::CNT_W-1:0] len;
  logic [spm_pkg::CNT_W-1:0] h_count;
  logic [spm_pkg::CNT_W-1:0] h_less;
  logic                      accept;
  logic                      active;
  logic                      f_now;
  logic                      slot_free;
  logic                      pend;
  logic                      pend_after;
  logic                      match;
  logic                      pop;

  logic [spm_pkg::CHAR_W-1:0]      shift_char [spm_pkg::MAX_PATTERN+1];
  logic [spm_pkg::MAX_PATTERN-1:0] eq;
  spm_pkg::cell_ctrl_t             ctrl [spm_pkg::MAX_PATTERN];

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;

  assign len = (pattern_length > spm_pkg::LEN_W'(spm_pkg::MAX_PATTERN)) ?
               spm_pkg::CNT_W'(spm_pkg::MAX_PATTERN) :
               pattern_length[spm_pkg::CNT_W-1:0];

  assign accept     = in_valid && in_ready;
  assign active     = busy || accept;
  assign f_now      = busy ? flush : end_of_text;
  assign h_count    = busy ? held : held + spm_pkg::CNT_W'(1);
  assign h_less     = h_count - spm_pkg::CNT_W'(1);
  assign slot_free  = !out_valid || out_ready;
  assign pend       = (h_count != '0) && ((h_count >= len) || f_now);
  assign pend_after = (h_less != '0) && ((h_less >= len) || f_now);
  assign match      = (&eq) && (len != '0) && (h_count >= len);
  assign pop        = active && pend && slot_free;

  assign shift_char[spm_pkg::MAX_PATTERN] = '0;

  for (genvar i = 0; i < spm_pkg::MAX_PATTERN; i++) begin : g_cell
    assign ctrl[i] = '{
      load: accept && (held == spm_pkg::CNT_W'(i)),
      pop:  pop,
      care: spm_pkg::CNT_W'(i) < len,
      mask: match && (spm_pkg::CNT_W'(i) < len)
    };

    spm_cell u_cell (
      .clk            (clk),
      .ctrl           (ctrl[i]),
      .char_in        (char_in),
      .pattern_char   (pattern_bytes[i*spm_pkg::CHAR_W +: spm_pkg::CHAR_W]),
      .neighbour_char (shift_char[i+1]),
      .shift_char     (shift_char[i]),
      .eq             (eq[i])
    );
  end

  always_comb begin
    held_next  = held;
    busy_next  = busy;
    flush_next = flush;
    if (active) begin
      held_next  = pop ? h_less : h_count;
      busy_next  = pop ? pend_after : pend;
      flush_next = f_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spm_pkg::REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        spm_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[spm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      busy      <= 1'b0;
      flush     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      held  <= held_next;
      busy  <= busy_next;
      flush <= flush_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      char_out <= shift_char[0];
      last_out <= f_now && (h_count == spm_pkg::CNT_W'(1));
    end
  end

endmodule

// ===== rtl/spm_checker.sv =====
`include "assert_macros.svh"

module spm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cfg_ready,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [spm_pkg::CHAR_W-1:0]        char_out,
  input logic                              last_out
);

  logic                        stall;
  logic [spm_pkg::CHAR_W:0]    out_word;

  assign stall    = out_valid && !out_ready;
  assign out_word = {char_out, last_out};

  `SPM_ASSERT(a_out_hold, clk, rst, stall |=> (out_valid && $stable(out_word)), "item changed")
  `SPM_ASSERT(a_busy_has_out, clk, rst, !in_ready |-> out_valid, "no item behind stall")
  `SPM_ASSERT_ALWAYS(a_reset_out, clk, rst |=> !out_valid, "output valid after reset")
  `SPM_ASSERT_ALWAYS(a_reset_in, clk, rst |=> (in_ready && cfg_ready), "not ready after reset")

endmodule

bind stream_pattern_masker_unit spm_checker u_spm_checker (.*);
